### src/b32enc_pkg.sv
// ----------------------------------------------------------------------------
// b32enc_pkg
// Types, codes and checksum helpers shared by the bech32 string encoder.
// ----------------------------------------------------------------------------
package b32enc_pkg;

	localparam int CHECK_W = 30;

	localparam logic [1:0] REQ_PREFIX = 2'd0;
	localparam logic [1:0] REQ_DATA   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	localparam logic [1:0] CMD_PREFIX     = 2'd0;
	localparam logic [1:0] CMD_PREFIX_ERR = 2'd1;
	localparam logic [1:0] CMD_DATA       = 2'd2;
	localparam logic [1:0] CMD_FINISH     = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	localparam logic [CHECK_W-1:0] CHECK_INIT = 30'd1;
	localparam logic [7:0]         SEP_CHAR   = 8'h31;
	localparam logic [2:0]         ZERO_LAST  = 3'd5;
	localparam logic [2:0]         CHK_LAST   = 3'd5;

	localparam logic [CHECK_W-1:0] GEN [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] item_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       error;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       walk;
		logic [7:0] item_byte;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CHECK_W-1:0] polymod_step(input logic [CHECK_W-1:0] c,
			input logic [4:0] v);
		logic [4:0]         top;
		logic [CHECK_W-1:0] r;
		top = c[29:25];
		r   = {c[24:0], 5'b0} ^ {25'b0, v};
		for (int j = 0; j < 5; j++) begin
			if (top[j]) begin
				r = r ^ GEN[j];
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] alpha_char(input logic [4:0] v);
		logic [7:0] ch;
		case (v)
			5'd0:  ch = "q";
			5'd1:  ch = "p";
			5'd2:  ch = "z";
			5'd3:  ch = "r";
			5'd4:  ch = "y";
			5'd5:  ch = "9";
			5'd6:  ch = "x";
			5'd7:  ch = "8";
			5'd8:  ch = "g";
			5'd9:  ch = "f";
			5'd10: ch = "2";
			5'd11: ch = "t";
			5'd12: ch = "v";
			5'd13: ch = "d";
			5'd14: ch = "w";
			5'd15: ch = "0";
			5'd16: ch = "s";
			5'd17: ch = "3";
			5'd18: ch = "j";
			5'd19: ch = "n";
			5'd20: ch = "5";
			5'd21: ch = "4";
			5'd22: ch = "k";
			5'd23: ch = "h";
			5'd24: ch = "c";
			5'd25: ch = "e";
			5'd26: ch = "6";
			5'd27: ch = "m";
			5'd28: ch = "u";
			5'd29: ch = "a";
			5'd30: ch = "7";
			default: ch = "l";
		endcase
		return ch;
	endfunction

endpackage

### src/b32enc_ram.sv
// ----------------------------------------------------------------------------
// b32enc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module b32enc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### src/b32enc_fifo.sv
// ----------------------------------------------------------------------------
// b32enc_fifo
// Short command queue between the classifying front and the encoding back.
// ----------------------------------------------------------------------------
module b32enc_fifo
	import b32enc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	cmd_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

### src/b32enc_front.sv
// ----------------------------------------------------------------------------
// b32enc_front
// Accepts request beats, tracks prefix length and data phase, and turns each
// prefix, payload or finish beat into a command for the back end.
// ----------------------------------------------------------------------------
module b32enc_front
	import b32enc_pkg::*;
#(
	parameter int HRP_MAX = 128,
	parameter int PW      = $clog2(HRP_MAX + 1)
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	output logic    item_stall,
	input  q_stat_t q_stat,
	output logic    push,
	output cmd_t    push_cmd
);

	logic [PW-1:0] plen_q;
	logic          data_q;
	logic          take;

	assign item_stall = q_stat.full;
	assign take       = item_valid && !q_stat.full;

	always_comb begin
		push               = 1'b0;
		push_cmd.kind      = CMD_DATA;
		push_cmd.walk      = !data_q;
		push_cmd.item_byte = item.item_byte;
		case (item.req_type)
			REQ_PREFIX: begin
				push = take;
				if (data_q || plen_q == PW'(HRP_MAX)) begin
					push_cmd.kind = CMD_PREFIX_ERR;
				end else begin
					push_cmd.kind = CMD_PREFIX;
				end
			end
			REQ_DATA: begin
				push          = take;
				push_cmd.kind = CMD_DATA;
			end
			REQ_FINISH: begin
				push          = take;
				push_cmd.kind = CMD_FINISH;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			data_q <= 1'b0;
		end else if (push) begin
			case (push_cmd.kind)
				CMD_PREFIX: begin
					plen_q <= plen_q + PW'(1);
				end
				CMD_DATA: begin
					data_q <= 1'b1;
				end
				CMD_FINISH: begin
					plen_q <= '0;
					data_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### src/b32enc_back.sv
// ----------------------------------------------------------------------------
// b32enc_back
// Executes commands: prefix store, prefix walk, 8 to 5 bit regrouping,
// checksum finish; at most one checksum update and one character per cycle.
// ----------------------------------------------------------------------------
module b32enc_back
	import b32enc_pkg::*;
#(
	parameter int HRP_MAX = 128,
	parameter int PW      = $clog2(HRP_MAX + 1),
	parameter int AW      = (HRP_MAX > 1) ? $clog2(HRP_MAX) : 1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  cmd_t    cmd,
	output logic    pop,
	output logic    sym_valid,
	output result_t sym,
	input  logic    sym_stall
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK0 = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_GROUP = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_ZERO  = 3'd5;
	localparam logic [2:0] ST_CHK   = 3'd6;

	logic [2:0]         state_q, state_d;
	logic [PW-1:0]      idx_q, idx_d, plen_q, plen_d, idx_inc;
	logic [CHECK_W-1:0] check_q, check_d, chk_q, chk_d, check_step;
	logic [3:0]         lbits_q, lbits_d;
	logic [2:0]         lcnt_q, lcnt_d;
	logic [11:0]        acc_q, acc_d, grp_wide;
	logic [3:0]         cnt_q, cnt_d, sh;
	logic [2:0]         zcnt_q, zcnt_d, ccnt_q, ccnt_d;
	logic               fin_q, fin_d;
	logic [4:0]         absorb_v, mask, grp_v, pad_v;
	logic [8:0]         pad_wide;
	logic               emit, out_free, ram_we;
	result_t            emit_res;
	logic [AW-1:0]      rd_addr;
	logic [4:0]         rd_data;
	logic               sym_valid_q;
	result_t            sym_q;

	b32enc_ram #(
		.WIDTH (5),
		.DEPTH (HRP_MAX)
	) u_prefix_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (plen_q[AW-1:0]),
		.wr_data (cmd.item_byte[4:0]),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free   = !sym_valid_q || !sym_stall;
	assign idx_inc    = idx_q + PW'(1);
	assign check_step = polymod_step(check_q, absorb_v);
	assign sh         = cnt_q - 4'd5;
	assign grp_wide   = acc_q >> sh;
	assign grp_v      = grp_wide[4:0];
	assign mask       = (5'd1 << sh[2:0]) - 5'd1;
	assign pad_wide   = {lbits_q, 5'b0} >> lcnt_q;
	assign pad_v      = pad_wide[4:0];

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		plen_d   = plen_q;
		check_d  = check_q;
		lbits_d  = lbits_q;
		lcnt_d   = lcnt_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		zcnt_d   = zcnt_q;
		chk_d    = chk_q;
		ccnt_d   = ccnt_q;
		fin_d    = fin_q;
		pop      = 1'b0;
		emit     = 1'b0;
		emit_res = '0;
		ram_we   = 1'b0;
		absorb_v = 5'd0;
		rd_addr  = idx_inc[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (cmd.kind)
						CMD_PREFIX: begin
							absorb_v = {2'b0, cmd.item_byte[7:5]};
							if (out_free) begin
								pop               = 1'b1;
								emit              = 1'b1;
								emit_res.out_char = cmd.item_byte;
								check_d           = check_step;
								ram_we            = 1'b1;
								plen_d            = plen_q + PW'(1);
							end
						end
						CMD_PREFIX_ERR: begin
							if (out_free) begin
								pop            = 1'b1;
								emit           = 1'b1;
								emit_res.error = 1'b1;
							end
						end
						default: begin
							pop   = 1'b1;
							fin_d = (cmd.kind == CMD_FINISH);
							acc_d = {lbits_q, cmd.item_byte};
							cnt_d = {1'b0, lcnt_q} + 4'd8;
							if (cmd.walk) begin
								state_d = ST_WALK0;
							end else if (cmd.kind == CMD_FINISH) begin
								state_d = ST_PAD;
							end else begin
								state_d = ST_GROUP;
							end
						end
					endcase
				end
			end
			ST_WALK0: begin
				check_d = check_step;
				idx_d   = '0;
				rd_addr = '0;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (idx_q != plen_q) begin
					absorb_v = rd_data;
					check_d  = check_step;
					idx_d    = idx_inc;
				end else if (out_free) begin
					emit              = 1'b1;
					emit_res.out_char = SEP_CHAR;
					state_d           = fin_q ? ST_PAD : ST_GROUP;
				end
			end
			ST_GROUP: begin
				absorb_v = grp_v;
				if (out_free) begin
					emit              = 1'b1;
					emit_res.out_char = alpha_char(grp_v);
					check_d           = check_step;
					if (sh < 4'd5) begin
						lbits_d = acc_q[3:0] & mask[3:0];
						lcnt_d  = sh[2:0];
						state_d = ST_IDLE;
					end else begin
						cnt_d = sh;
					end
				end
			end
			ST_PAD: begin
				absorb_v = pad_v;
				zcnt_d   = '0;
				if (lcnt_q == '0) begin
					state_d = ST_ZERO;
				end else if (out_free) begin
					emit              = 1'b1;
					emit_res.out_char = alpha_char(pad_v);
					check_d           = check_step;
					state_d           = ST_ZERO;
				end
			end
			ST_ZERO: begin
				check_d = check_step;
				zcnt_d  = zcnt_q + 3'd1;
				if (zcnt_q == ZERO_LAST) begin
					chk_d   = check_step ^ CHECK_INIT;
					ccnt_d  = '0;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (out_free) begin
					emit              = 1'b1;
					emit_res.out_char = alpha_char(chk_q[29:25]);
					emit_res.last     = (ccnt_q == CHK_LAST);
					chk_d             = {chk_q[24:0], 5'b0};
					ccnt_d            = ccnt_q + 3'd1;
					if (ccnt_q == CHK_LAST) begin
						check_d = CHECK_INIT;
						lbits_d = '0;
						lcnt_d  = '0;
						plen_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plen_q      <= '0;
			check_q     <= CHECK_INIT;
			lbits_q     <= '0;
			lcnt_q      <= '0;
			sym_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			plen_q  <= plen_d;
			check_q <= check_d;
			lbits_q <= lbits_d;
			lcnt_q  <= lcnt_d;
			if (emit) begin
				sym_valid_q <= 1'b1;
			end else if (!sym_stall) begin
				sym_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		acc_q  <= acc_d;
		cnt_q  <= cnt_d;
		zcnt_q <= zcnt_d;
		chk_q  <= chk_d;
		ccnt_q <= ccnt_d;
		fin_q  <= fin_d;
		if (emit) begin
			sym_q <= emit_res;
		end
	end

	assign sym_valid = sym_valid_q;
	assign sym       = sym_q;

endmodule

### src/bech32_string_encoder_core.sv
// ----------------------------------------------------------------------------
// bech32_string_encoder_core
// Streams one bech32 string per message from prefix, payload and finish beats.
// ----------------------------------------------------------------------------
// A front end classifies each request beat (prefix, prefix error, payload,
// finish) into a four-entry command queue, so requests keep flowing while
// the back end works; beats with the unused request code are dropped. The
// back end makes at most one checksum update and writes at most one
// character per cycle into an output register. A prefix character or
// refused prefix emits one beat. A payload byte is dispatched and then
// emits one or two characters. The first payload byte or finish of a
// message adds a prefix walk through the prefix RAM read port. Finish emits
// an optional pad character, makes six zero absorbs and emits six checksum
// characters. Character output holds while sym_stall is high.
// ----------------------------------------------------------------------------
module bech32_string_encoder_core
	import b32enc_pkg::*;
#(
	parameter int HRP_MAX = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	output logic    item_stall,
	output logic    sym_valid,
	output result_t sym,
	input  logic    sym_stall
);

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;

	b32enc_front #(
		.HRP_MAX (HRP_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	b32enc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	b32enc_back #(
		.HRP_MAX (HRP_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.cmd       (head),
		.pop       (pop),
		.sym_valid (sym_valid),
		.sym       (sym),
		.sym_stall (sym_stall)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("command pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command popped from empty queue");

	a_stall_tracks_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && $past(q_stat.empty) |=> !q_stat.empty)
		else $error("queue lost a command");

	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym.error |-> !sym.last && sym.out_char == '0)
		else $error("error beat carries a character");

endmodule

### tb/tb_bech32_string_encoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bech32_string_encoder_core
// Self-checking bench for the bech32 string encoder core.
// ----------------------------------------------------------------------------
// Prefix, payload and finish beats go in over the request channel. A
// scoreboard keeps its own checksum, 8-to-5 regrouping and prefix store and
// builds the characters that each beat should produce. Every character beat
// that comes out is checked in order against them. Directed messages cover
// empty messages, empty prefixes, padding at leftover counts 0, 1 and 4, refused
// prefix characters and the unused request code. Random messages follow,
// with one that overruns the prefix store. Both sides idle and stall at
// random, with a quiet stretch.
// ----------------------------------------------------------------------------
module tb_bech32_string_encoder_core;
	import b32enc_pkg::*;

	localparam int PREFIX_CAP = 128;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	class enc_scoreboard;
		logic [29:0] chk;
		logic [3:0]  carry_bits;
		logic [2:0]  carry_cnt;
		logic [4:0]  hrp_low [PREFIX_CAP];
		int          hrp_len;
		bit          in_data;
		result_t     pending [$];
		int          errors;
		logic [29:0] poly [5];
		string       charset;

		function new();
			poly = '{30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3};
			charset = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
			errors = 0;
			restart();
		endfunction

		function void restart();
			chk = 30'd1;
			carry_bits = '0;
			carry_cnt = '0;
			hrp_len = 0;
			in_data = 1'b0;
		endfunction

		function void absorb(logic [4:0] v);
			logic [4:0]  top;
			logic [29:0] c;
			top = chk[29:25];
			c = {chk[24:0], 5'b0} ^ {25'b0, v};
			for (int j = 0; j < 5; j++) begin
				if (top[j]) begin
					c = c ^ poly[j];
				end
			end
			chk = c;
		endfunction

		function void push(logic [7:0] ch, logic lst, logic err);
			result_t r;
			r.out_char = ch;
			r.last = lst;
			r.error = err;
			pending.push_back(r);
		endfunction

		function void emit_group(logic [4:0] v);
			absorb(v);
			push(charset[v], 1'b0, 1'b0);
		endfunction

		function void walk_hrp();
			if (in_data) begin
				return;
			end
			absorb(5'd0);
			for (int i = 0; i < hrp_len; i++) begin
				absorb(hrp_low[i]);
			end
			push(8'h31, 1'b0, 1'b0);
			in_data = 1'b1;
		endfunction

		function void note_item(item_t it);
			int          acc;
			int          cnt;
			logic [29:0] c;
			case (it.req_type)
				REQ_PREFIX: begin
					if (in_data || hrp_len >= PREFIX_CAP) begin
						push(8'h00, 1'b0, 1'b1);
					end else begin
						absorb({2'b0, it.item_byte[7:5]});
						hrp_low[hrp_len] = it.item_byte[4:0];
						hrp_len++;
						push(it.item_byte, 1'b0, 1'b0);
					end
				end
				REQ_DATA: begin
					walk_hrp();
					acc = (int'(carry_bits) << 8) | int'(it.item_byte);
					cnt = int'(carry_cnt) + 8;
					while (cnt >= 5) begin
						cnt -= 5;
						emit_group(5'((acc >> cnt) & 31));
					end
					carry_cnt = 3'(cnt);
					carry_bits = 4'(acc & ((1 << cnt) - 1));
				end
				REQ_FINISH: begin
					walk_hrp();
					if (carry_cnt > 0 && carry_cnt < 5) begin
						emit_group(5'((int'(carry_bits) << (5 - int'(carry_cnt))) & 31));
					end
					for (int i = 0; i < 6; i++) begin
						absorb(5'd0);
					end
					c = chk ^ 30'd1;
					for (int i = 0; i < 6; i++) begin
						push(charset[5'((c >> (5 * (5 - i))) & 30'd31)], i == 5, 1'b0);
					end
					restart();
				end
				default: begin
				end
			endcase
		endfunction

		function void check_sym(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual char %h last %b error %b",
					$time, got.out_char, got.last, got.error);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_char !== want.out_char) begin
				$display("%0t: out_char mismatch, expected %h, actual %h",
					$time, want.out_char, got.out_char);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch, expected %b, actual %b", $time, want.last, got.last);
				errors++;
			end
			if (got.error !== want.error) begin
				$display("%0t: error mismatch, expected %b, actual %b",
					$time, want.error, got.error);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	item_t   item;
	logic    item_stall;
	logic    sym_valid;
	result_t sym;
	logic    sym_stall;

	enc_scoreboard book;
	bit            gaps_on;
	int            sent;

	bech32_string_encoder_core #(
		.HRP_MAX(PREFIX_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.sym_valid(sym_valid),
		.sym(sym),
		.sym_stall(sym_stall)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	// output side stalls
	initial begin
		sym_stall = 1'b0;
		forever begin
			@(negedge clk);
			sym_stall <= gaps_on && ($urandom_range(0, 99) < 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sym_valid && !sym_stall) begin
			book.check_sym(sym);
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
		item_t it;
		it.req_type = kind;
		it.item_byte = b;
		while (gaps_on && $urandom_range(0, 99) < 12) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		book.note_item(it);
		if (kind != REQ_UNUSED) begin
			sent++;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (book.pending.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic random_message(input int n_hrp, input int n_data);
		for (int i = 0; i < n_hrp; i++) begin
			send_item(REQ_PREFIX, 8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < n_data; i++) begin
			send_item(REQ_DATA, 8'($urandom_range(0, 255)));
			case ($urandom_range(0, 19))
				0: send_item(REQ_PREFIX, 8'($urandom_range(0, 255)));
				1: send_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
				default: begin
				end
			endcase
		end
		send_item(REQ_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		book = new();
		gaps_on = 1'b1;
		sent = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty prefix, empty payload
		send_item(REQ_FINISH, 8'hff);
		// prefix only
		send_item(REQ_PREFIX, 8'h61);
		send_item(REQ_FINISH, 8'h00);
		// payload extremes
		send_item(REQ_PREFIX, 8'h62);
		send_item(REQ_PREFIX, 8'h63);
		send_item(REQ_DATA, 8'h00);
		send_item(REQ_DATA, 8'hff);
		send_item(REQ_FINISH, 8'h00);
		// refused prefix after payload, unused code
		send_item(REQ_PREFIX, 8'h00);
		send_item(REQ_DATA, 8'h80);
		send_item(REQ_PREFIX, 8'hff);
		send_item(REQ_DATA, 8'h01);
		send_item(REQ_UNUSED, 8'h5a);
		send_item(REQ_FINISH, 8'h00);
		// leftover counts 3, 1, then 3, 1, 4; finish pads after 1 and after 4
		send_item(REQ_PREFIX, 8'hff);
		send_item(REQ_DATA, 8'h55);
		send_item(REQ_DATA, 8'haa);
		send_item(REQ_FINISH, 8'h00);
		send_item(REQ_DATA, 8'h0f);
		send_item(REQ_DATA, 8'hf0);
		send_item(REQ_DATA, 8'h3c);
		send_item(REQ_FINISH, 8'h00);

		item_valid <= 1'b0;
		wait_drained();
		@(negedge clk);

		// overrun the prefix store, no idling on either side
		gaps_on = 1'b0;
		random_message(PREFIX_CAP + 2, 3);
		gaps_on = 1'b1;

		while (sent < 180) begin
			if ($urandom_range(0, 9) == 0) begin
				random_message($urandom_range(0, 12), $urandom_range(0, 20));
			end else begin
				random_message($urandom_range(0, 5), $urandom_range(0, 8));
			end
		end
		item_valid <= 1'b0;

		wait_drained();
		repeat (50) @(posedge clk);
		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
